FILE: sv/vwap_and_top_movers_assert.svh
// assertion macros for the vwap and top movers block
`ifndef VWAP_AND_TOP_MOVERS_ASSERT_SVH
`define VWAP_AND_TOP_MOVERS_ASSERT_SVH
// implication checked on every clock edge outside reset
`define VTM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define VTM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: sv/vtm_pkg.sv
// package with types and constants for the vwap and top movers block
package vtm_pkg;
  localparam int TOP_COUNT = 5;
  localparam int MAX_DAYS = 1024;
  localparam int TOP_W = $clog2(TOP_COUNT + 1);
  localparam int CNT_W = $clog2(MAX_DAYS + 1);
  localparam logic [38:0] VOL_MAX = '1;

  typedef struct packed {
    logic [26:0] day_code;
    logic [23:0] open_price;
    logic [23:0] high_price;
    logic [23:0] low_price;
    logic [23:0] close_price;
    logic [27:0] traded_volume;
    logic        final_day;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  rank;
    logic [26:0] mover_day;
    logic [31:0] move_percent;
    logic [27:0] mover_volume;
    logic [23:0] vwap_price;
    logic        vwap_valid;
    logic [26:0] busiest_day;
    logic [27:0] busiest_volume;
    logic [26:0] quietest_day;
    logic [27:0] quietest_volume;
    logic        overflowed;
    logic        last_result;
  } out_item_t;
endpackage

FILE: sv/vwap_and_top_movers.sv
// top level of the vwap and top movers block
//
// usage: pulse start with a daily bar on item while busy is low; the bar is
// taken as one transaction and busy rises on the next cycle.
// per bar: a 64-step restoring divider forms the percent move after a load
// step, the move is then picked, the top list is walked slot by slot with a
// single compare unit, then an update step follows; busy stays high until
// the bar is through, so a new bar is taken only once busy is low again.
// a product (high+low+close)*volume is formed once per bar, as the bar is taken.
// on a bar with final_day set the same divider then forms the vwap, and
// up to TOP_COUNT results leave on result, each for exactly one
// cycle with strobe high, biggest move first, last_result on the final one.
// the receiver cannot stall; results are simply presented in order.
// after the report all state clears, ready for the next data set.
// with no held days at the final mark no result is issued.
// reset (rst, synchronous) clears all accumulators and the ranked list and
// returns the sequencer to idle; no clearing pass is needed.
// bars after MAX_DAYS are ignored and set the overflow flag.
module vwap_and_top_movers
  import vtm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  item,
  output logic      busy,
  output logic      strobe,
  output out_item_t result
);
`include "vwap_and_top_movers_assert.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_VDIV = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state;
  in_item_t    bar;
  // shared divider: 64-bit dividend, 41-bit divisor
  logic [63:0] quo;
  logic [41:0] rem;
  logic [40:0] dvs;
  logic [6:0]  step;
  logic [31:0] move;
  logic [TOP_W-1:0] pos;
  logic        placed;

  logic [CNT_W-1:0] day_count;
  logic [38:0] volume_total;
  logic [63:0] weighted_sum;
  logic        overflow_flag;
  logic [27:0] max_volume_value, min_volume_value;
  logic [26:0] max_volume_day, min_volume_day;
  logic [31:0] top_moves [TOP_COUNT];
  logic [26:0] top_days [TOP_COUNT];
  logic [27:0] top_volumes [TOP_COUNT];
  logic [63:0] prod;
  logic [23:0] vwap;
  logic [TOP_W-1:0] held, out_idx;

  logic [41:0] rem_sh;
  logic [42:0] rem_try;
  logic [23:0] diff;
  logic [64:0] sum_w;
  logic [39:0] sum_v;

  assign busy = (state != S_IDLE);
  assign held = (day_count < CNT_W'(TOP_COUNT)) ? TOP_W'(day_count) : TOP_W'(TOP_COUNT);
  assign rem_sh = {rem[40:0], quo[63]};
  assign rem_try = {1'b0, rem_sh} - {2'b0, dvs};
  assign diff = (bar.close_price > bar.open_price) ? bar.close_price - bar.open_price
                                                   : bar.open_price - bar.close_price;
  assign sum_w = {1'b0, weighted_sum} + {1'b0, prod};
  assign sum_v = {1'b0, volume_total} + 40'(bar.traded_volume);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      strobe <= 1'b0;
      day_count <= '0;
      volume_total <= '0;
      weighted_sum <= '0;
      overflow_flag <= 1'b0;
      max_volume_value <= '0;
      max_volume_day <= '0;
      min_volume_value <= '1;
      min_volume_day <= '0;
      for (int i = 0; i < TOP_COUNT; i++) begin
        top_moves[i] <= '0;
        top_days[i] <= '0;
        top_volumes[i] <= '0;
      end
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            bar <= item;
            prod <= 64'(26'(item.high_price) + 26'(item.low_price) + 26'(item.close_price))
                    * 64'(item.traded_volume);
            step <= '0;
            rem <= '0;
            dvs <= 41'(item.open_price);
            if (day_count >= CNT_W'(MAX_DAYS)) begin
              overflow_flag <= 1'b1;
              state <= S_ACC;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (step == 7'd0) begin
            // diff*100 << 16 as dividend
            quo <= {16'd0, 32'(diff) * 32'd100, 16'd0};
            step <= 7'd1;
          end else begin
            if (!rem_try[42]) begin
              rem <= rem_try[41:0];
              quo <= {quo[62:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[62:0], 1'b0};
            end
            if (step == 7'd64) begin
              state <= S_INS;
            end
            step <= step + 7'd1;
          end
        end
        S_INS: begin
          move <= (bar.open_price == '0 || quo[63:32] != '0) ? '1 : quo[31:0];
          pos <= held;
          placed <= 1'b0;
          out_idx <= '0;
          state <= S_ACC;
          step <= '0;
        end
        S_ACC: begin
          // first phase walks slots to find insert position, one per cycle
          if (day_count < CNT_W'(MAX_DAYS) && !placed) begin
            if (out_idx < held && move > top_moves[out_idx[TOP_W-1:0]]) begin
              pos <= out_idx;
              placed <= 1'b1;
            end else if (out_idx >= held) begin
              placed <= 1'b1;
            end else begin
              out_idx <= out_idx + 1'b1;
            end
          end else begin
            if (day_count < CNT_W'(MAX_DAYS)) begin
              if (pos < TOP_W'(TOP_COUNT)) begin
                for (int i = TOP_COUNT - 1; i > 0; i--) begin
                  if (TOP_W'(i) > pos) begin
                    top_moves[i] <= top_moves[i-1];
                    top_days[i] <= top_days[i-1];
                    top_volumes[i] <= top_volumes[i-1];
                  end
                end
                top_moves[pos[TOP_W-1:0]] <= move;
                top_days[pos[TOP_W-1:0]] <= bar.day_code;
                top_volumes[pos[TOP_W-1:0]] <= bar.traded_volume;
              end
              if (day_count == '0 || bar.traded_volume > max_volume_value) begin
                max_volume_value <= bar.traded_volume;
                max_volume_day <= bar.day_code;
              end
              if (day_count == '0 || bar.traded_volume < min_volume_value) begin
                min_volume_value <= bar.traded_volume;
                min_volume_day <= bar.day_code;
              end
              if (sum_v > {1'b0, VOL_MAX}) begin
                volume_total <= VOL_MAX;
                overflow_flag <= 1'b1;
              end else begin
                volume_total <= sum_v[38:0];
              end
              if (sum_w[64]) begin
                weighted_sum <= '1;
                overflow_flag <= 1'b1;
              end else begin
                weighted_sum <= sum_w[63:0];
              end
              day_count <= day_count + 1'b1;
            end
            if (bar.final_day) begin
              state <= S_VDIV;
              step <= '0;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_VDIV: begin
          if (step == 7'd0) begin
            quo <= weighted_sum;
            rem <= '0;
            dvs <= 41'(volume_total) * 41'd3;
            step <= 7'd1;
          end else if (step <= 7'd64) begin
            if (!rem_try[42]) begin
              rem <= rem_try[41:0];
              quo <= {quo[62:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[62:0], 1'b0};
            end
            step <= step + 7'd1;
          end else begin
            vwap <= (volume_total == '0) ? '0 : (quo[63:24] != '0) ? '1 : quo[23:0];
            out_idx <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_idx < held) begin
            strobe <= 1'b1;
            result.rank <= 3'(out_idx);
            result.mover_day <= top_days[out_idx[TOP_W-1:0]];
            result.move_percent <= top_moves[out_idx[TOP_W-1:0]];
            result.mover_volume <= top_volumes[out_idx[TOP_W-1:0]];
            result.vwap_price <= vwap;
            result.vwap_valid <= (volume_total != '0);
            result.busiest_day <= max_volume_day;
            result.busiest_volume <= max_volume_value;
            result.quietest_day <= min_volume_day;
            result.quietest_volume <= min_volume_value;
            result.overflowed <= overflow_flag;
            result.last_result <= (out_idx + 1'b1 == held);
            out_idx <= out_idx + 1'b1;
          end else begin
            day_count <= '0;
            volume_total <= '0;
            weighted_sum <= '0;
            overflow_flag <= 1'b0;
            max_volume_value <= '0;
            max_volume_day <= '0;
            min_volume_value <= '1;
            min_volume_day <= '0;
            for (int i = 0; i < TOP_COUNT; i++) begin
              top_moves[i] <= '0;
              top_days[i] <= '0;
              top_volumes[i] <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `VTM_ASSERT_IMP(a_strobe_in_out, strobe, $past(state) == S_OUT)
  `VTM_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `VTM_ASSERT_IMP(a_day_cap, 1'b1, day_count <= CNT_W'(MAX_DAYS))
endmodule

FILE: sim/vwap_and_top_movers_tb.sv
// self-checking testbench for the vwap and top movers block
module vwap_and_top_movers_tb;
  import vtm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_BARS = 280;
  localparam int HEAVY_BARS = 24;
  localparam int DRAIN_CYCLES = 200;

  logic      clk;
  logic      rst;
  logic      start;
  in_item_t  item;
  logic      busy;
  logic      strobe;
  out_item_t result;

  vwap_and_top_movers uut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .strobe(strobe), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state, mirrors the block's accumulators
  logic [10:0] days_held;
  logic [38:0] vol_sum;
  logic [63:0] price_vol_sum;
  logic        sat_seen;
  logic [27:0] peak_vol;
  logic [26:0] peak_day;
  logic [27:0] trough_vol;
  logic [26:0] trough_day;
  logic [31:0] rank_move [TOP_COUNT];
  logic [26:0] rank_day [TOP_COUNT];
  logic [27:0] rank_vol [TOP_COUNT];

  out_item_t report_queue[$];
  int        fail_count = 0;
  int        idle_cycles;
  logic      timed_out = 1'b0;

  task automatic clear_tracker();
    days_held = '0;
    vol_sum = '0;
    price_vol_sum = '0;
    sat_seen = 1'b0;
    peak_vol = '0;
    peak_day = '0;
    trough_vol = '1;
    trough_day = '0;
    for (int i = 0; i < TOP_COUNT; i++) begin
      rank_move[i] = '0;
      rank_day[i] = '0;
      rank_vol[i] = '0;
    end
  endtask

  function automatic logic [31:0] move_of(logic [23:0] o, logic [23:0] c);
    logic [63:0] diff;
    logic [63:0] q;
    if (o == 0) return 32'hFFFF_FFFF;
    diff = (c > o) ? 64'(c - o) : 64'(o - c);
    q = ((diff * 64'd100) << 16) / 64'(o);
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  // update the tracker with one bar, queue the report on the final one
  task automatic track_bar(in_item_t b);
    logic [31:0] mv;
    int          held;
    int          pos;
    logic [63:0] prod;
    logic [63:0] quot;
    logic [23:0] vwap;
    logic        valid;
    out_item_t   r;
    if (days_held >= MAX_DAYS) begin
      sat_seen = 1'b1;
    end else begin
      mv = move_of(b.open_price, b.close_price);
      held = (days_held < TOP_COUNT) ? int'(days_held) : TOP_COUNT;
      pos = held;
      for (int i = 0; i < held; i++) begin
        if (mv > rank_move[i]) begin
          pos = i;
          break;
        end
      end
      if (pos < TOP_COUNT) begin
        for (int i = (held < TOP_COUNT ? held : TOP_COUNT - 1); i > pos; i--) begin
          rank_move[i] = rank_move[i-1];
          rank_day[i] = rank_day[i-1];
          rank_vol[i] = rank_vol[i-1];
        end
        rank_move[pos] = mv;
        rank_day[pos] = b.day_code;
        rank_vol[pos] = b.traded_volume;
      end
      if (days_held == 0 || b.traded_volume > peak_vol) begin
        peak_vol = b.traded_volume;
        peak_day = b.day_code;
      end
      if (days_held == 0 || b.traded_volume < trough_vol) begin
        trough_vol = b.traded_volume;
        trough_day = b.day_code;
      end
      if (VOL_MAX - vol_sum < 39'(b.traded_volume)) begin
        vol_sum = VOL_MAX;
        sat_seen = 1'b1;
      end else begin
        vol_sum = vol_sum + 39'(b.traded_volume);
      end
      prod = (64'(b.high_price) + 64'(b.low_price) + 64'(b.close_price))
             * 64'(b.traded_volume);
      if (64'hFFFF_FFFF_FFFF_FFFF - price_vol_sum < prod) begin
        price_vol_sum = '1;
        sat_seen = 1'b1;
      end else begin
        price_vol_sum = price_vol_sum + prod;
      end
      days_held = days_held + 11'd1;
    end
    if (b.final_day) begin
      held = (days_held < TOP_COUNT) ? int'(days_held) : TOP_COUNT;
      valid = (vol_sum != 0);
      vwap = '0;
      if (valid) begin
        quot = price_vol_sum / (64'(vol_sum) * 64'd3);
        vwap = (quot > 64'hFF_FFFF) ? 24'hFF_FFFF : quot[23:0];
      end
      for (int k = 0; k < held; k++) begin
        r.rank = 3'(k);
        r.mover_day = rank_day[k];
        r.move_percent = rank_move[k];
        r.mover_volume = rank_vol[k];
        r.vwap_price = vwap;
        r.vwap_valid = valid;
        r.busiest_day = peak_day;
        r.busiest_volume = peak_vol;
        r.quietest_day = trough_day;
        r.quietest_volume = trough_vol;
        r.overflowed = sat_seen;
        r.last_result = (k + 1 == held);
        report_queue.insert(report_queue.size(), r);
      end
      clear_tracker();
    end
  endtask

  // compare each strobed result with the oldest expected report row
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && strobe) begin
      if (report_queue.size() == 0) begin
        $error("unexpected result transaction rank=%0d", result.rank);
        fail_count++;
      end else begin
        e = report_queue.pop_front();
        if (result.rank !== e.rank) begin
          $error("rank exp %0d got %0d", e.rank, result.rank); fail_count++;
        end
        if (result.mover_day !== e.mover_day) begin
          $error("mover_day exp %0d got %0d", e.mover_day, result.mover_day);
          fail_count++;
        end
        if (result.move_percent !== e.move_percent) begin
          $error("move_percent exp %h got %h", e.move_percent, result.move_percent);
          fail_count++;
        end
        if (result.mover_volume !== e.mover_volume) begin
          $error("mover_volume exp %0d got %0d", e.mover_volume, result.mover_volume);
          fail_count++;
        end
        if (result.vwap_price !== e.vwap_price) begin
          $error("vwap_price exp %h got %h", e.vwap_price, result.vwap_price);
          fail_count++;
        end
        if (result.vwap_valid !== e.vwap_valid) begin
          $error("vwap_valid exp %b got %b", e.vwap_valid, result.vwap_valid);
          fail_count++;
        end
        if (result.busiest_day !== e.busiest_day) begin
          $error("busiest_day exp %0d got %0d", e.busiest_day, result.busiest_day);
          fail_count++;
        end
        if (result.busiest_volume !== e.busiest_volume) begin
          $error("busiest_volume exp %0d got %0d", e.busiest_volume,
                 result.busiest_volume);
          fail_count++;
        end
        if (result.quietest_day !== e.quietest_day) begin
          $error("quietest_day exp %0d got %0d", e.quietest_day, result.quietest_day);
          fail_count++;
        end
        if (result.quietest_volume !== e.quietest_volume) begin
          $error("quietest_volume exp %0d got %0d", e.quietest_volume,
                 result.quietest_volume);
          fail_count++;
        end
        if (result.overflowed !== e.overflowed) begin
          $error("overflowed exp %b got %b", e.overflowed, result.overflowed);
          fail_count++;
        end
        if (result.last_result !== e.last_result) begin
          $error("last_result exp %b got %b", e.last_result, result.last_result);
          fail_count++;
        end
      end
    end
  end

  // watchdog: cycles with no accepted transaction on either side
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("vwap_and_top_movers test failed");
      $finish;
    end
  end

  // sender gap, mostly short, sometimes long, often none
  task automatic sender_gap();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: n = 0;
      9: n = $urandom_range(20, 120);
      default: n = $urandom_range(1, 6);
    endcase
    repeat (n) @(posedge clk);
  endtask

  // present one bar and hold start until the block takes it
  task automatic send_bar(in_item_t b);
    start <= 1'b1;
    item <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    track_bar(b);
    start <= 1'b0;
    // the block is busy on this edge, so no acceptance is lost
    @(posedge clk);
  endtask

  function automatic in_item_t make_bar(logic [26:0] d, logic [23:0] o,
                                        logic [23:0] h, logic [23:0] l,
                                        logic [23:0] c, logic [27:0] v,
                                        logic f);
    in_item_t b;
    b.day_code = d; b.open_price = o; b.high_price = h;
    b.low_price = l; b.close_price = c; b.traded_volume = v; b.final_day = f;
    return b;
  endfunction

  // random bar: prices near a base mostly, with corner values mixed in
  function automatic in_item_t random_bar(logic f);
    in_item_t    b;
    logic [23:0] base;
    base = 24'($urandom_range(1, 24'hFF_FFFF));
    b.day_code = 27'($urandom_range(0, 99991231));
    b.open_price = ($urandom_range(0, 15) == 0) ? 24'($urandom_range(0, 2)) :
                   ($urandom_range(0, 15) == 0) ? 24'hFF_FFFF : base;
    b.close_price = ($urandom_range(0, 7) == 0) ? 24'($urandom) :
                    24'(base + $urandom_range(0, 4096) - 2048);
    b.high_price = 24'($urandom);
    b.low_price = 24'($urandom);
    case ($urandom_range(0, 7))
      0: b.traded_volume = '0;
      1: b.traded_volume = '1;
      2: b.traded_volume = 28'($urandom_range(0, 3));
      default: b.traded_volume = 28'($urandom);
    endcase
    b.final_day = f;
    return b;
  endfunction

  // directed table: expected row typed in where obvious, else predicted
  typedef struct {
    in_item_t  bar;
    logic      fixed;
    out_item_t row;
  } step_t;

  step_t steps[$];

  task automatic add_step(in_item_t b);
    step_t s;
    s.bar = b; s.fixed = 1'b0; s.row = '0;
    steps.insert(steps.size(), s);
  endtask

  initial begin
    step_t     s;
    out_item_t r;
    int        set_len;
    int        sent;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    clear_tracker();

    // single zero-open zero-close bar: saturated move, vwap invalid
    s.bar = make_bar(27'd20240101, 24'd0, 24'd0, 24'd0, 24'd0, 28'd0, 1'b1);
    s.fixed = 1'b1;
    r = '0;
    r.mover_day = 27'd20240101;
    r.move_percent = 32'hFFFF_FFFF;
    r.busiest_day = 27'd20240101;
    r.quietest_day = 27'd20240101;
    r.last_result = 1'b1;
    s.row = r;
    steps.insert(steps.size(), s);
    // equal moves and equal volumes, then fewer than five days
    add_step(make_bar(27'd1, 24'd256, 24'd300, 24'd200, 24'd512, 28'd7, 1'b0));
    add_step(make_bar(27'd2, 24'd256, 24'd300, 24'd200, 24'd512, 28'd7, 1'b0));
    add_step(make_bar(27'd3, 24'd256, 24'd256, 24'd256, 24'd256, 28'd7, 1'b1));
    // extremes and large move saturation over seven days
    add_step(make_bar(27'd99991231, 24'd1, 24'hFF_FFFF, 24'hFF_FFFF,
                      24'hFF_FFFF, 28'hFFF_FFFF, 1'b0));
    add_step(make_bar(27'd0, 24'hFF_FFFF, 24'd0, 24'd0, 24'd0, 28'd0, 1'b0));
    add_step(make_bar(27'd5, 24'hFF_FFFF, 24'hFF_FFFF, 24'd0,
                      24'hFF_FFFF, 28'd1, 1'b0));
    add_step(make_bar(27'd6, 24'd1000, 24'd1100, 24'd900, 24'd1100, 28'd500, 1'b0));
    add_step(make_bar(27'd7, 24'd1000, 24'd1100, 24'd900, 24'd900, 28'd500, 1'b0));
    add_step(make_bar(27'd8, 24'd1000, 24'd1100, 24'd900, 24'd1050, 28'd499, 1'b0));
    add_step(make_bar(27'd9, 24'd0, 24'd1, 24'd1, 24'd5, 28'hFFF_FFFF, 1'b1));
    // all-zero volume set with two days
    add_step(make_bar(27'd10, 24'd100, 24'd10, 24'd10, 24'd10, 28'd0, 1'b0));
    add_step(make_bar(27'd11, 24'd100, 24'd10, 24'd10, 24'd150, 28'd0, 1'b1));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (steps[i]) begin
      sender_gap();
      send_bar(steps[i].bar);
      if (steps[i].fixed) begin
        // replace the predicted row with the one read off by hand
        void'(report_queue.pop_back());
        report_queue.insert(report_queue.size(), steps[i].row);
      end
    end

    // pause until every report row has come out
    while (report_queue.size() != 0) @(posedge clk);

    // one set of heavy bars with large sums
    for (int i = 0; i < HEAVY_BARS; i++) begin
      in_item_t b;
      b = random_bar(i == HEAVY_BARS - 1);
      if (i % 4 == 0) begin
        b.traded_volume = '1;
        b.high_price = '1; b.low_price = '1; b.close_price = '1;
      end
      send_bar(b);
    end
    while (report_queue.size() != 0) @(posedge clk);

    // random sets, mostly short, with a final mark each
    sent = 0;
    while (sent < RANDOM_BARS) begin
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                             : $urandom_range(1, 8);
      for (int j = 0; j < set_len; j++) begin
        sender_gap();
        send_bar(random_bar(j == set_len - 1));
        sent++;
      end
      if ($urandom_range(0, 5) == 0) begin
        while (report_queue.size() != 0) @(posedge clk);
      end
    end

    while (report_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("vwap_and_top_movers test passed");
    end else begin
      $display("vwap_and_top_movers test failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+sv
sv/vtm_pkg.sv
sv/vwap_and_top_movers.sv
sim/vwap_and_top_movers_tb.sv
